/* hw/rtl/slrg_pkg.sv */
// shared types, constants, helper functions and microcode rom for the subtractive generator
package slrg_pkg;

   localparam int TABLE_LEN  = 55;
   localparam int IDX_W      = 6;
   localparam int WORD_W     = 30;
   localparam int SEED_W     = 32;
   localparam int MIX_PASSES = 4;
   localparam int FILL_STEP  = 21;
   localparam int FAR_START  = 31;
   localparam int LAG_OFS    = 30;
   localparam int CNT_W      = 8;
   localparam int UPC_W      = 4;

   localparam logic [SEED_W-1:0] MODULUS   = 32'd1000000000;
   localparam logic [SEED_W-1:0] SEED_BASE = 32'd161803398;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [SEED_W-1:0] seed_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [UPC_W-1:0]  upc_type;

   localparam idx_type LAST_ADDR   = idx_type'(TABLE_LEN - 1);
   localparam idx_type FILL_ADDR0  = idx_type'(FILL_STEP - 1);
   localparam idx_type MIX_B_ADDR0 = idx_type'(LAG_OFS + 1);
   localparam cnt_type FILL_COUNT  = cnt_type'(TABLE_LEN - 1);
   localparam cnt_type MIX_COUNT   = cnt_type'(MIX_PASSES * TABLE_LEN);

   // microcode step addresses
   localparam upc_type UPC_IDLE    = 4'd0;
   localparam upc_type UPC_MAG     = 4'd1;
   localparam upc_type UPC_ABS     = 4'd2;
   localparam upc_type UPC_SEED    = 4'd3;
   localparam upc_type UPC_FILL    = 4'd4;
   localparam upc_type UPC_MIX_SET = 4'd5;
   localparam upc_type UPC_MIX_RD  = 4'd6;
   localparam upc_type UPC_MIX_WR  = 4'd7;
   localparam upc_type UPC_ARM     = 4'd8;
   localparam upc_type UPC_DRAW_RD = 4'd9;
   localparam upc_type UPC_DRAW_WR = 4'd10;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MAG,
      OP_ABS,
      OP_SEED,
      OP_FILL,
      OP_MIX_SET,
      OP_MIX_RD,
      OP_MIX_WR,
      OP_ARM,
      OP_DRAW_RD,
      OP_DRAW_WR
   } dp_op_type;

   typedef enum logic [1:0] {
      GATE_NONE,
      GATE_REQ,
      GATE_RSP
   } gate_type;

   typedef enum logic [1:0] {
      JC_NEXT,
      JC_ALWAYS,
      JC_LOOP,
      JC_DISPATCH
   } jc_type;

   typedef enum logic [1:0] {
      CL_NONE,
      CL_FILL,
      CL_MIX
   } cnt_load_type;

   typedef struct packed {
      dp_op_type    op;
      gate_type     gate;
      jc_type       jc;
      cnt_load_type cl;
      upc_type      target;
   } uword_type;

   typedef struct packed {
      dp_op_type op;
   } slrg_ctl_type;

   typedef struct packed {
      logic seeded;
      logic out_busy;
      logic seed_neg;
   } slrg_stat_type;

   // (a - b) mod 10^9 for a, b below the modulus
   function automatic word_type sub_mod(word_type a, word_type b);
      logic [WORD_W:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (d[WORD_W]) begin
         d = d + MODULUS[WORD_W:0];
      end
      return d[WORD_W-1:0];
   endfunction

   // table index steps circularly over 1..55
   function automatic idx_type next_index(idx_type i);
      return (i >= idx_type'(TABLE_LEN)) ? idx_type'(1) : i + idx_type'(1);
   endfunction

   // memory address steps circularly over 0..54
   function automatic idx_type addr_inc(idx_type a);
      return (a >= LAST_ADDR) ? idx_type'(0) : a + idx_type'(1);
   endfunction

   // fill order: next address is 21 further, modulo 55
   function automatic idx_type addr_fill_step(idx_type a);
      logic [IDX_W:0] s;
      s = {1'b0, a} + (IDX_W+1)'(FILL_STEP);
      if (s >= (IDX_W+1)'(TABLE_LEN)) begin
         s = s - (IDX_W+1)'(TABLE_LEN);
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic uword_type ucode_rom(upc_type pc);
      uword_type w;
      w = '{op: OP_NONE, gate: GATE_NONE, jc: JC_NEXT, cl: CL_NONE, target: UPC_IDLE};
      case (pc)
         UPC_IDLE: begin
            w.op = OP_LOAD; w.gate = GATE_REQ; w.jc = JC_DISPATCH;
         end
         UPC_MAG:     w.op = OP_MAG;
         UPC_ABS:     w.op = OP_ABS;
         UPC_SEED: begin
            w.op = OP_SEED; w.cl = CL_FILL;
         end
         UPC_FILL: begin
            w.op = OP_FILL; w.jc = JC_LOOP; w.target = UPC_FILL;
         end
         UPC_MIX_SET: begin
            w.op = OP_MIX_SET; w.cl = CL_MIX;
         end
         UPC_MIX_RD:  w.op = OP_MIX_RD;
         UPC_MIX_WR: begin
            w.op = OP_MIX_WR; w.jc = JC_LOOP; w.target = UPC_MIX_RD;
         end
         UPC_ARM:     w.op = OP_ARM;
         UPC_DRAW_RD: w.op = OP_DRAW_RD;
         UPC_DRAW_WR: begin
            w.op = OP_DRAW_WR; w.gate = GATE_RSP; w.jc = JC_ALWAYS; w.target = UPC_IDLE;
         end
         default: begin
            w.jc = JC_ALWAYS; w.target = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

/* hw/rtl/slrg_if.sv */
// request and response channel interfaces of the subtractive generator
interface slrg_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] seed;

   modport source (output valid, output seed, input ready);
   modport sink (input valid, input seed, output ready);
endinterface

interface slrg_rsp_if;
   logic        valid;
   logic        ready;
   logic [29:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

/* hw/rtl/slrg_seq.sv */
// microcode sequencer: step counter, loop counter and rom-driven jumps
module slrg_seq
   import slrg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  slrg_stat_type stat,
   output slrg_ctl_type  ctl
);

   upc_type   pc_ff, pc_in;
   cnt_type   cnt_ff, cnt_in;
   uword_type uw;
   logic      stall;

   always_comb begin
      uw    = ucode_rom(pc_ff);
      stall = ((uw.gate == GATE_REQ) && !req_valid) ||
              ((uw.gate == GATE_RSP) && stat.out_busy);
      req_ready = (uw.gate == GATE_REQ);
      ctl.op    = stall ? OP_NONE : uw.op;

      pc_in  = pc_ff;
      cnt_in = cnt_ff;
      if (!stall) begin
         case (uw.jc)
            JC_NEXT:   pc_in = pc_ff + upc_type'(1);
            JC_ALWAYS: pc_in = uw.target;
            JC_LOOP: begin
               pc_in  = (cnt_ff != cnt_type'(1)) ? uw.target : pc_ff + upc_type'(1);
               cnt_in = cnt_ff - cnt_type'(1);
            end
            JC_DISPATCH: pc_in = (stat.seed_neg || !stat.seeded) ? UPC_MAG : UPC_DRAW_RD;
            default:   pc_in = UPC_IDLE;
         endcase
         case (uw.cl)
            CL_FILL: cnt_in = FILL_COUNT;
            CL_MIX:  cnt_in = MIX_COUNT;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= UPC_IDLE;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_loop_count_live: assert property (@(posedge clock) disable iff (reset)
      ((pc_ff == UPC_FILL) || (pc_ff == UPC_MIX_WR)) |-> (cnt_ff != '0))
      else $error("loop step entered with empty count");

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      (pc_ff <= UPC_DRAW_WR))
      else $error("step counter left the program");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ((pc_ff == UPC_MAG) || (pc_ff == UPC_DRAW_RD)))
      else $error("request accepted without dispatch");
`endif

endmodule

/* hw/rtl/slrg_dp.sv */
// datapath: lag table memory, seed arithmetic, modular subtract and output register
module slrg_dp
   import slrg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  slrg_ctl_type  ctl,
   input  seed_type      req_seed,
   output slrg_stat_type stat,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output word_type      rsp_value
);

   word_type lag_mem [TABLE_LEN];

   seed_type seed_ff, seed_in;
   seed_type acc_ff, acc_in;
   word_type cur_ff, cur_in;
   word_type prev_ff, prev_in;
   idx_type  addr_a_ff, addr_a_in;
   idx_type  addr_b_ff, addr_b_in;
   idx_type  near_ff, near_in;
   idx_type  far_ff, far_in;
   logic     seeded_ff, seeded_in;
   logic     rsp_valid_ff, rsp_valid_in;
   word_type value_ff, value_in;
   word_type rd_a_ff, rd_b_ff;

   logic     wr_en, rd_en;
   idx_type  wr_addr, ra, rb;
   word_type wr_data;
   logic [SEED_W:0] diff;
   seed_type red;
   idx_type  nn, fn;

   always_comb begin
      seed_in      = seed_ff;
      acc_in       = acc_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      addr_a_in    = addr_a_ff;
      addr_b_in    = addr_b_ff;
      near_in      = near_ff;
      far_in       = far_ff;
      seeded_in    = seeded_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      wr_addr      = addr_a_ff;
      wr_data      = prev_ff;
      ra           = addr_a_ff;
      rb           = addr_b_ff;
      diff         = {1'b0, SEED_BASE} - {1'b0, acc_ff};
      red          = (acc_ff >= MODULUS) ? acc_ff - MODULUS : acc_ff;
      nn           = next_index(near_ff);
      fn           = next_index(far_ff);

      case (ctl.op)
         OP_LOAD: seed_in = req_seed;
         OP_MAG:  acc_in = seed_ff[SEED_W-1] ? (~seed_ff + seed_type'(1)) : seed_ff;
         // magnitude of base minus seed magnitude
         OP_ABS:  acc_in = diff[SEED_W] ? (acc_ff - SEED_BASE) : diff[SEED_W-1:0];
         OP_SEED: begin
            wr_en     = 1'b1;
            wr_addr   = LAST_ADDR;
            wr_data   = red[WORD_W-1:0];
            cur_in    = red[WORD_W-1:0];
            prev_in   = word_type'(1);
            addr_a_in = FILL_ADDR0;
         end
         OP_FILL: begin
            wr_en     = 1'b1;
            wr_data   = prev_ff;
            prev_in   = sub_mod(cur_ff, prev_ff);
            cur_in    = prev_ff;
            addr_a_in = addr_fill_step(addr_a_ff);
         end
         OP_MIX_SET: begin
            addr_a_in = '0;
            addr_b_in = MIX_B_ADDR0;
         end
         OP_MIX_RD: rd_en = 1'b1;
         OP_MIX_WR: begin
            wr_en     = 1'b1;
            wr_data   = sub_mod(rd_a_ff, rd_b_ff);
            addr_a_in = addr_inc(addr_a_ff);
            addr_b_in = addr_inc(addr_b_ff);
         end
         OP_ARM: begin
            near_in   = '0;
            far_in    = idx_type'(FAR_START);
            seeded_in = 1'b1;
         end
         OP_DRAW_RD: begin
            rd_en   = 1'b1;
            near_in = nn;
            far_in  = fn;
            ra      = nn - idx_type'(1);
            rb      = fn - idx_type'(1);
         end
         OP_DRAW_WR: begin
            wr_en        = 1'b1;
            wr_addr      = near_ff - idx_type'(1);
            wr_data      = sub_mod(rd_a_ff, rd_b_ff);
            value_in     = wr_data;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lag_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= lag_mem[ra];
         rd_b_ff <= lag_mem[rb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff      <= '0;
         far_ff       <= idx_type'(FAR_START);
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         near_ff      <= near_in;
         far_ff       <= far_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff   <= seed_in;
      acc_ff    <= acc_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      value_ff  <= value_in;
   end

   assign stat.seeded   = seeded_ff;
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;
   assign stat.seed_neg = req_seed[SEED_W-1];
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = value_ff;

`ifndef ASSERT_OFF
   a_draw_after_build: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_DRAW_RD) |-> seeded_ff)
      else $error("draw issued before the table was built");

   a_lag_distance: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_DRAW_WR) |->
         (far_ff == ((near_ff <= idx_type'(24)) ? near_ff + idx_type'(31)
                                               : near_ff - idx_type'(24))))
      else $error("near and far indices lost their lag");

   a_rsp_from_draw: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.op == OP_DRAW_WR))
      else $error("response raised without a draw");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_DRAW_WR) |-> !(rsp_valid_ff && !rsp_ready))
      else $error("draw overwrote a pending response");
`endif

endmodule

/* hw/rtl/subtractive_lagged_random_generator.sv */
// top level of the subtractive lagged generator (modulus 10^9, 55-entry lag table)
// usage:
//   req carries a signed 32-bit seed; rsp returns one 30-bit value 0..999999999 per request,
//   the uniform fraction being value / 10^9. both channels use valid/ready.
//   a request is taken only when the sequencer sits at its idle step.
// sequence:
//   a plain draw steps through accept, table read of both lagged entries, then write-back
//   and response register load. rsp.valid rises the cycle after that.
//   a negative seed, or the first request after reset, rebuilds the table first: seed
//   arithmetic (magnitude, absolute difference, seeding), 54 fill writes, 220 mixing
//   updates, each a read then a write, and one arming step. the single write port of the
//   table memory and the read-then-write mixing loop set this order of steps.
// reset:
//   clears the step counter, the response valid and marks the table as not built; the
//   table memory itself is not cleared, the first request always rebuilds it.
// stalls:
//   a finished response waits in its register; the next request is still accepted and
//   runs until its own write-back step, where it holds until rsp.ready frees the register.
module subtractive_lagged_random_generator
   import slrg_pkg::*;
(
   input logic         clock,
   input logic         reset,
   slrg_req_if.sink    req,
   slrg_rsp_if.source  rsp
);

   slrg_ctl_type  ctl;
   slrg_stat_type stat;

   slrg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   slrg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_seed  (seed_type'(req.seed)),
      .stat      (stat),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .rsp_value (rsp.value)
   );

endmodule
